@@ rtl/evh_pkg.sv @@
// Shared types and constants for the job occupancy event store.
// Used by evh_mem and job_occupancy_event_heap_unit; depends on nothing.
package evh_pkg;

	localparam int unsigned EVH_SLOTS = 1024;
	localparam logic [19:0] BUSY_MAX  = 20'hFFFFF;

	typedef struct packed {
		logic [31:0] submit_time;
		logic [31:0] begin_time;
		logic [31:0] end_time;
		logic [15:0] node_count;
	} evh_job_t;

	typedef struct packed {
		logic [19:0] busy_nodes;
		logic        store_overflow;
	} evh_result_t;

	typedef struct packed {
		logic [31:0] time_val;
		logic [15:0] nodes;
		logic        is_start;
	} evh_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RET_RD,
		ST_RET_CHK,
		ST_INS_BEGIN,
		ST_INS_RD,
		ST_INS_CHK
	} evh_state_t;

endpackage

@@ rtl/evh_mem.sv @@
// Single-port-write, single-port-read event memory with a registered read.
// Depends on evh_pkg for the entry type.
module evh_mem
	import evh_pkg::*;
#(
	parameter int unsigned DEPTH = EVH_SLOTS,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  evh_entry_t    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output evh_entry_t    rdata
);

	evh_entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/job_occupancy_event_heap_unit.sv @@
// Top level of the job occupancy event store: sequencer, counters and result register.
// Depends on evh_pkg and evh_mem.
//
//   channel   signals              direction   beat taken when
//   job       start, busy, job     in          start && !busy at a rising edge
//   result    done, result         out         done high for one cycle
//
// Events sit time-sorted in a circular buffer held in one memory.
// A job spends a read and a check state per retired event, a read and a shift state per
// entry shifted during each insert, plus overhead states (fewer when the store is full);
// done rises in the cycle after the last of these. The single memory read port sets this.
// Reset empties the store at once; no clearing pass is needed.
// The result is shown for exactly one cycle and cannot be stalled.
module job_occupancy_event_heap_unit
	import evh_pkg::*;
#(
	parameter int unsigned EVENT_SLOTS = EVH_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  evh_job_t    job,
	output logic        done,
	output evh_result_t result
);

	localparam int unsigned AW = $clog2(EVENT_SLOTS);
	localparam int unsigned CW = $clog2(EVENT_SLOTS + 1);
	localparam logic [CW:0]   SLOTS_X = (CW + 1)'(EVENT_SLOTS);
	localparam logic [CW-1:0] SLOTS_C = CW'(EVENT_SLOTS);
	localparam logic [AW-1:0] LAST_A  = AW'(EVENT_SLOTS - 1);

	evh_state_t  state_q, state_d;
	evh_job_t    job_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] pos_q;
	logic [19:0] inuse_q;
	logic        ovf_q;
	logic        which_q;
	logic        done_q;
	evh_result_t result_q;

	logic        mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	evh_entry_t  mem_wdata, mem_rdata, new_ev;
	logic [CW:0] wsum, rsum;
	logic [AW-1:0] addr_w, addr_r;
	logic [CW-1:0] pos_m1;
	logic [20:0] add_sum;
	logic [19:0] nodes_x, inuse_next;

	evh_mem #(.DEPTH(EVENT_SLOTS), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign pos_m1 = pos_q - 1'b1;
	assign wsum   = {{(CW + 1 - AW){1'b0}}, head_q} + {1'b0, pos_q};
	assign rsum   = {{(CW + 1 - AW){1'b0}}, head_q} + {1'b0, pos_m1};
	assign addr_w = (wsum >= SLOTS_X) ? AW'(wsum - SLOTS_X) : AW'(wsum);
	assign addr_r = (rsum >= SLOTS_X) ? AW'(rsum - SLOTS_X) : AW'(rsum);

	assign new_ev.time_val = which_q ? job_q.end_time : job_q.begin_time;
	assign new_ev.nodes    = job_q.node_count;
	assign new_ev.is_start = !which_q;

	assign nodes_x = {4'd0, mem_rdata.nodes};
	assign add_sum = {1'b0, inuse_q} + {1'b0, nodes_x};
	always_comb begin
		if (mem_rdata.is_start) begin
			inuse_next = (add_sum > {1'b0, BUSY_MAX}) ? BUSY_MAX : add_sum[19:0];
		end else begin
			inuse_next = (nodes_x > inuse_q) ? 20'd0 : inuse_q - nodes_x;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = addr_w;
		mem_wdata = new_ev;
		mem_re    = 1'b0;
		mem_raddr = head_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_RET_RD;
				end
			end
			ST_RET_RD: begin
				if (fill_q == '0) begin
					state_d = ST_INS_BEGIN;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_RET_CHK;
				end
			end
			ST_RET_CHK: begin
				state_d = (mem_rdata.time_val <= job_q.submit_time) ? ST_RET_RD : ST_INS_BEGIN;
			end
			ST_INS_BEGIN: begin
				if (fill_q == SLOTS_C && which_q) begin
					state_d = ST_IDLE;
				end else if (fill_q != SLOTS_C) begin
					state_d = ST_INS_RD;
				end
			end
			ST_INS_RD: begin
				if (pos_q == '0) begin
					mem_we  = 1'b1;
					state_d = which_q ? ST_IDLE : ST_INS_BEGIN;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = addr_r;
					state_d   = ST_INS_CHK;
				end
			end
			ST_INS_CHK: begin
				mem_we = 1'b1;
				if (mem_rdata.time_val > new_ev.time_val) begin
					mem_wdata = mem_rdata;
					state_d   = ST_INS_RD;
				end else begin
					state_d = which_q ? ST_IDLE : ST_INS_BEGIN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			fill_q  <= '0;
			inuse_q <= '0;
			done_q  <= 1'b0;
			ovf_q   <= 1'b0;
			which_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						ovf_q   <= 1'b0;
						which_q <= 1'b0;
					end
				end
				ST_RET_CHK: begin
					if (mem_rdata.time_val <= job_q.submit_time) begin
						inuse_q <= inuse_next;
						head_q  <= (head_q == LAST_A) ? '0 : head_q + 1'b1;
						fill_q  <= fill_q - 1'b1;
					end
				end
				ST_INS_BEGIN: begin
					if (fill_q == SLOTS_C) begin
						ovf_q <= 1'b1;
						if (which_q) begin
							done_q <= 1'b1;
						end else begin
							which_q <= 1'b1;
						end
					end else begin
						pos_q <= fill_q;
					end
				end
				ST_INS_RD: begin
					if (pos_q == '0) begin
						fill_q <= fill_q + 1'b1;
						if (which_q) begin
							done_q <= 1'b1;
						end else begin
							which_q <= 1'b1;
						end
					end
				end
				ST_INS_CHK: begin
					if (mem_rdata.time_val > new_ev.time_val) begin
						pos_q <= pos_m1;
					end else begin
						fill_q <= fill_q + 1'b1;
						if (which_q) begin
							done_q <= 1'b1;
						end else begin
							which_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			job_q <= job;
		end
		result_q.busy_nodes <= inuse_q;
		result_q.store_overflow <= ovf_q || (state_q == ST_INS_BEGIN && fill_q == SLOTS_C);
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

@@ dv/tb_job_occupancy_event_heap_unit.sv @@
// Self-checking testbench for job_occupancy_event_heap_unit: job beats are predicted
// against a sorted event list kept here, and every result beat is compared in order.
// Depends on evh_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_job_occupancy_event_heap_unit;
	import evh_pkg::*;

	localparam int unsigned WATCHDOG_CYCLES = 100000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	evh_job_t    job;
	logic        done;
	evh_result_t result;

	evh_entry_t  pending_events[$];
	logic [19:0] nodes_busy_model;
	evh_result_t expected_results[$];
	int unsigned mismatch_count;
	int unsigned idle_cycles;
	int unsigned burst_left;
	logic [31:0] clock_now;

	job_occupancy_event_heap_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.job    (job),
		.done   (done),
		.result (result)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic logic queue_event(logic [31:0] t, logic [15:0] n, logic is_start);
		evh_entry_t e;
		int pos;
		if (pending_events.size() >= EVH_SLOTS)
			return 1'b1;
		e.time_val = t;
		e.nodes    = n;
		e.is_start = is_start;
		pos = pending_events.size();
		while (pos > 0 && pending_events[pos - 1].time_val > t)
			pos--;
		pending_events.insert(pos, e);
		return 1'b0;
	endfunction

	function automatic evh_result_t occupancy_after(evh_job_t j);
		evh_result_t r;
		logic [20:0] sum;
		logic        ovf;
		while (pending_events.size() > 0 && pending_events[0].time_val <= j.submit_time) begin
			if (pending_events[0].is_start) begin
				sum = {1'b0, nodes_busy_model} + pending_events[0].nodes;
				nodes_busy_model = sum[20] ? BUSY_MAX : sum[19:0];
			end else if (pending_events[0].nodes > nodes_busy_model) begin
				nodes_busy_model = '0;
			end else begin
				nodes_busy_model = nodes_busy_model - pending_events[0].nodes;
			end
			void'(pending_events.pop_front());
		end
		r.busy_nodes = nodes_busy_model;
		ovf = queue_event(j.begin_time, j.node_count, 1'b1);
		ovf = queue_event(j.end_time, j.node_count, 1'b0) | ovf;
		r.store_overflow = ovf;
		return r;
	endfunction

	// Called at a rising edge; after the edge that takes the beat it may drop start and wait before it returns.
	task automatic send_job(input logic [31:0] ts, input logic [31:0] tb,
			input logic [31:0] te, input logic [15:0] n);
		evh_job_t j;
		j.submit_time = ts;
		j.begin_time  = tb;
		j.end_time    = te;
		j.node_count  = n;
		start <= 1'b1;
		job   <= j;
		do
			@(posedge clk);
		while (busy);
		expected_results.push_back(occupancy_after(j));
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	always @(posedge clk) begin
		if (done) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result beat: busy_nodes=%0d overflow=%0b",
						result.busy_nodes, result.store_overflow);
			end else begin
				if (result !== expected_results[0]) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: busy_nodes exp %0d got %0d, overflow exp %0b got %0b",
							expected_results[0].busy_nodes, result.busy_nodes,
							expected_results[0].store_overflow, result.store_overflow);
				end
				void'(expected_results.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic test_extremes();
		send_job(32'd0, 32'd0, 32'd0, 16'd0);
		send_job(32'd1, 32'd5, 32'd10, 16'd100);
		send_job(32'd5, 32'd5, 32'd5, 16'hFFFF);
		send_job(32'd5, 32'd7, 32'd7, 16'd3);
		send_job(32'd8, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hA5A5);
		send_job(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'h5A5A);
		send_job(32'hFFFFFFFF, 32'd0, 32'd0, 16'd1);
	endtask

	task automatic test_count_bounds();
		repeat (17) send_job(32'd100, 32'd100, 32'hFFFFFFFE, 16'hFFFF);
		send_job(32'd101, 32'd200, 32'd150, 16'd9);
		send_job(32'hFFFFFFFF, 32'd10, 32'd5, 16'd7);
		send_job(32'd0, 32'd10, 32'd5, 16'd7);
		send_job(32'd6, 32'd20, 32'd30, 16'd1);
		send_job(32'hFFFFFFFF, 32'd0, 32'd0, 16'd0);
	endtask

	task automatic test_store_full();
		for (int i = 0; i < EVH_SLOTS / 2; i++)
			send_job(32'd0, 32'd1000 + 2 * i, 32'd1001 + 2 * i, 16'($urandom));
		send_job(32'd0, 32'd5, 32'd6, 16'd4);
		send_job(32'd999, 32'd2, 32'd3, 16'd4);
		send_job(32'hFFFFFFFF, 32'd0, 32'd0, 16'd0);
	endtask

	task automatic test_random_jobs();
		logic [31:0] tb;
		logic [15:0] n;
		clock_now = 32'd0;
		repeat (700) begin
			if ($urandom_range(0, 99) < 85) begin
				clock_now = clock_now + $urandom_range(0, 20);
				tb = clock_now + $urandom_range(0, 30);
				case ($urandom_range(0, 3))
					0: n = 16'hFFFF;
					1: n = 16'($urandom);
					default: n = 16'($urandom_range(0, 300));
				endcase
				send_job(clock_now, tb, tb + $urandom_range(0, 60), n);
			end else begin
				send_job($urandom, $urandom, $urandom, 16'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		job = '0;
		nodes_busy_model = '0;
		mismatch_count = 0;
		idle_cycles = 0;
		burst_left = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_count_bounds();
		test_store_full();
		test_random_jobs();
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/evh_pkg.sv
rtl/evh_mem.sv
rtl/job_occupancy_event_heap_unit.sv
dv/tb_job_occupancy_event_heap_unit.sv
